### rtl/bezier_curve_point_eval_top_macros.svh
// Assertion macros used by the checker file of this block.
`ifndef BEZIER_CURVE_POINT_EVAL_TOP_MACROS_SVH
`define BEZIER_CURVE_POINT_EVAL_TOP_MACROS_SVH

// Same-cycle implication, ignored while reset is high.
`define BCPE_ASSERT_NOW(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |-> (cons)) \
      else $error("assertion failed: lbl");

// Next-cycle implication, ignored while reset is high.
`define BCPE_ASSERT_NEXT(lbl, clk, rst, ante, cons) \
   lbl: assert property (@(posedge clk) disable iff (rst) (ante) |=> (cons)) \
      else $error("assertion failed: lbl");

`endif

### rtl/bcpe_pkg.sv
`timescale 1ns / 1ps
`default_nettype none
package bcpe_pkg;

   localparam int MAX_POINTS_DEF = 16;

   localparam logic [16:0] ONE_Q16    = 17'd65536;
   localparam logic [16:0] PICK_RESET = 17'd6554;
   // Binomial coefficients saturate here; any weight with a larger one clamps.
   localparam logic [16:0] BINOM_CAP  = 17'd65537;

   localparam logic [1:0] REQ_APPEND = 2'd0;
   localparam logic [1:0] REQ_MOVE   = 2'd1;
   localparam logic [1:0] REQ_EVAL   = 2'd2;
   localparam logic [1:0] REQ_PICK   = 2'd3;

   localparam logic [1:0] ST_OK      = 2'd0;
   localparam logic [1:0] ST_FULL    = 2'd1;
   localparam logic [1:0] ST_BAD_IDX = 2'd2;
   localparam logic [1:0] ST_NONE    = 2'd3;

   localparam int MUL_AW = 33;
   localparam int MUL_BW = 18;
   localparam int MUL_PW = MUL_AW + MUL_BW;

endpackage
`default_nettype wire

### rtl/bezier_curve_point_eval_top.sv
`timescale 1ns / 1ps
`default_nettype none
// Append and move write the table at acceptance. Evaluate works over the n stored
// points, all on one shared multiplier; pick walks the table one entry at a time.
// One item at a time: a new item is taken once the sequencer is idle.
// Reset (synchronous, active high) empties the table and sets pick_radius to 0.1;
// the point storage itself is not cleared.
module bezier_curve_point_eval_top #(
   parameter int MAX_POINTS = bcpe_pkg::MAX_POINTS_DEF
) (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   output logic             req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_px,
   input  wire logic [31:0] req_py,
   input  wire logic [16:0] req_t_param,
   input  wire logic [3:0]  req_point_index,
   output logic             rsp_valid,
   input  wire logic        rsp_ready,
   output logic [31:0]      rsp_out_x,
   output logic [31:0]      rsp_out_y,
   output logic [3:0]       rsp_found_index,
   output logic [1:0]       rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data
);

   // Count width holds MAX_POINTS itself; index width addresses the table.
   localparam int CW   = $clog2(MAX_POINTS + 1);
   localparam int IW   = $clog2(MAX_POINTS);
   localparam int CMPW = (CW > 4) ? CW : 4;
   localparam int AW   = 56;

   // Sequencer states.
   localparam logic [3:0] S_IDLE  = 4'd0;
   localparam logic [3:0] S_ROW   = 4'd1;
   localparam logic [3:0] S_PINIT = 4'd2;
   localparam logic [3:0] S_PMUL  = 4'd3;
   localparam logic [3:0] S_WMUL  = 4'd4;
   localparam logic [3:0] S_XMUL  = 4'd5;
   localparam logic [3:0] S_YMUL  = 4'd6;
   localparam logic [3:0] S_YACC  = 4'd7;
   localparam logic [3:0] S_PACK  = 4'd8;
   localparam logic [3:0] S_RSQ   = 4'd9;
   localparam logic [3:0] S_PRD   = 4'd10;
   localparam logic [3:0] S_PDX   = 4'd11;
   localparam logic [3:0] S_SQX   = 4'd12;
   localparam logic [3:0] S_SQY   = 4'd13;
   localparam logic [3:0] S_CMP   = 4'd14;
   localparam logic [3:0] S_DONE  = 4'd15;

   logic [3:0] state_ff, state_in;

   // Control point storage, written at one address and read with a registered port.
   logic [31:0] mem_x [MAX_POINTS];
   logic [31:0] mem_y [MAX_POINTS];
   logic [31:0] rd_x_ff, rd_y_ff;

   logic [CW-1:0] count_ff, count_in;
   logic [16:0]   radius_ff;

   logic [31:0] px_ff, px_in, py_ff, py_in;
   logic [16:0] t_ff, t_in, u_val;
   logic [IW-1:0] idx_ff, idx_in;   // table entry being worked on
   logic [IW-1:0] k_ff, k_in;       // inner loop counter
   logic [IW-1:0] m_val;

   // Pascal row of binomial coefficients, one saturating adder per lane but the first.
   logic [16:0] row_ff [MAX_POINTS];
   logic        row_init, row_step;

   logic [16:0] p_ff, p_in, w_ff, w_in;
   logic signed [bcpe_pkg::MUL_PW-1:0] prod_ff, prod_in;
   logic signed [AW-1:0] acc_x_ff, acc_x_in, acc_y_ff, acc_y_in;

   logic [16:0] dx_ff, dx_in, dy_ff, dy_in;
   logic [33:0] sq_ff, sq_in, rsq_ff, rsq_in;

   logic [31:0] res_x_ff, res_x_in, res_y_ff, res_y_in;
   logic [3:0]  res_f_ff, res_f_in;
   logic [1:0]  res_s_ff, res_s_in;

   logic        rsp_valid_ff, rsp_valid_in;
   logic [31:0] rsp_x_ff, rsp_y_ff;
   logic [3:0]  rsp_f_ff;
   logic [1:0]  rsp_s_ff;
   logic        rsp_load;

   logic signed [bcpe_pkg::MUL_AW-1:0] mul_a;
   logic signed [bcpe_pkg::MUL_BW-1:0] mul_b;
   logic signed [bcpe_pkg::MUL_PW-1:0] mul_p;

   logic accept;
   logic wr_en;
   logic [IW-1:0] wr_addr;
   logic [CMPW-1:0] idx_req_ext, count_ext;
   logic signed [32:0] dxs, dys;
   logic [32:0] dx_abs, dy_abs;
   logic [33:0] dist_sum;

   function automatic logic [31:0] sat32(input logic signed [AW-1:0] a);
      logic signed [AW-17:0] s;
      s = a[AW-1:16];
      if (s > (AW-16)'(64'sd2147483647)) begin
         sat32 = 32'h7FFF_FFFF;
      end else if (s < -(AW-16)'(64'sd2147483648)) begin
         sat32 = 32'h8000_0000;
      end else begin
         sat32 = s[31:0];
      end
   endfunction

   bcpe_mul u_mul (
      .mul_a (mul_a),
      .mul_b (mul_b),
      .mul_p (mul_p)
   );

   assign accept      = req_valid && req_ready;
   assign req_ready   = (state_ff == S_IDLE);
   assign u_val       = bcpe_pkg::ONE_Q16 - t_ff;
   assign m_val       = IW'(count_ff - CW'(1));
   assign idx_req_ext = CMPW'(req_point_index);
   assign count_ext   = CMPW'(count_ff);

   // Table write happens at acceptance for append and move.
   always_comb begin
      wr_en   = 1'b0;
      wr_addr = IW'(count_ff);
      if (accept && req_type == bcpe_pkg::REQ_APPEND && count_ff < CW'(MAX_POINTS)) begin
         wr_en = 1'b1;
      end else if (accept && req_type == bcpe_pkg::REQ_MOVE && idx_req_ext < count_ext) begin
         wr_en   = 1'b1;
         wr_addr = IW'(idx_req_ext);
      end
   end

   always_ff @(posedge clock) begin
      if (wr_en) begin
         mem_x[wr_addr] <= req_px;
         mem_y[wr_addr] <= req_py;
      end
      rd_x_ff <= mem_x[idx_ff];
      rd_y_ff <= mem_y[idx_ff];
   end

   // Distance terms for pick.
   assign dxs      = {px_ff[31], px_ff} - {rd_x_ff[31], rd_x_ff};
   assign dys      = {py_ff[31], py_ff} - {rd_y_ff[31], rd_y_ff};
   assign dx_abs   = dxs[32] ? 33'(-dxs) : 33'(dxs);
   assign dy_abs   = dys[32] ? 33'(-dys) : 33'(dys);
   assign dist_sum = sq_ff + 34'(prod_ff[33:0]);

   // Operand selection for the shared multiplier.
   always_comb begin
      mul_a = '0;
      mul_b = '0;
      case (state_ff)
         S_PMUL: begin
            mul_a = {16'd0, p_ff};
            mul_b = (k_ff < idx_ff) ? {1'b0, t_ff} : {1'b0, u_val};
         end
         S_WMUL: begin
            mul_a = {16'd0, row_ff[idx_ff]};
            mul_b = {1'b0, p_ff};
         end
         S_XMUL: begin
            mul_a = {rd_x_ff[31], rd_x_ff};
            mul_b = {1'b0, w_ff};
         end
         S_YMUL: begin
            mul_a = {rd_y_ff[31], rd_y_ff};
            mul_b = {1'b0, w_ff};
         end
         S_RSQ: begin
            mul_a = {16'd0, radius_ff};
            mul_b = {1'b0, radius_ff};
         end
         S_SQX: begin
            mul_a = {16'd0, dx_ff};
            mul_b = {1'b0, dx_ff};
         end
         S_SQY: begin
            mul_a = {16'd0, dy_ff};
            mul_b = {1'b0, dy_ff};
         end
         default: begin
            mul_a = '0;
            mul_b = '0;
         end
      endcase
   end

   // Sequencer.
   always_comb begin
      state_in = state_ff;
      count_in = count_ff;
      px_in    = px_ff;
      py_in    = py_ff;
      t_in     = t_ff;
      idx_in   = idx_ff;
      k_in     = k_ff;
      p_in     = p_ff;
      w_in     = w_ff;
      prod_in  = prod_ff;
      acc_x_in = acc_x_ff;
      acc_y_in = acc_y_ff;
      dx_in    = dx_ff;
      dy_in    = dy_ff;
      sq_in    = sq_ff;
      rsq_in   = rsq_ff;
      res_x_in = res_x_ff;
      res_y_in = res_y_ff;
      res_f_in = res_f_ff;
      res_s_in = res_s_ff;
      row_init = 1'b0;
      row_step = 1'b0;
      rsp_load = 1'b0;
      case (state_ff)
         S_IDLE: begin
            if (accept) begin
               px_in    = req_px;
               py_in    = req_py;
               t_in     = (req_t_param > bcpe_pkg::ONE_Q16) ? bcpe_pkg::ONE_Q16 : req_t_param;
               res_x_in = '0;
               res_y_in = '0;
               res_f_in = '0;
               res_s_in = bcpe_pkg::ST_OK;
               idx_in   = '0;
               k_in     = '0;
               acc_x_in = '0;
               acc_y_in = '0;
               state_in = S_DONE;
               case (req_type)
                  bcpe_pkg::REQ_APPEND: begin
                     if (count_ff < CW'(MAX_POINTS)) begin
                        count_in = count_ff + CW'(1);
                     end else begin
                        res_s_in = bcpe_pkg::ST_FULL;
                     end
                  end
                  bcpe_pkg::REQ_MOVE: begin
                     if (!(idx_req_ext < count_ext)) begin
                        res_s_in = bcpe_pkg::ST_BAD_IDX;
                     end
                  end
                  bcpe_pkg::REQ_EVAL: begin
                     if (count_ff != '0) begin
                        row_init = 1'b1;
                        state_in = (m_val == '0) ? S_PINIT : S_ROW;
                     end
                  end
                  default: begin
                     res_s_in = bcpe_pkg::ST_NONE;
                     if (count_ff != '0) begin
                        state_in = S_RSQ;
                     end
                  end
               endcase
            end
         end
         S_ROW: begin
            row_step = 1'b1;
            if (k_ff == m_val - IW'(1)) begin
               state_in = S_PINIT;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         S_PINIT: begin
            p_in     = bcpe_pkg::ONE_Q16;
            k_in     = '0;
            state_in = (m_val == '0) ? S_WMUL : S_PMUL;
         end
         S_PMUL: begin
            p_in = mul_p[32:16];
            if (k_ff == m_val - IW'(1)) begin
               state_in = S_WMUL;
            end else begin
               k_in = k_ff + IW'(1);
            end
         end
         S_WMUL: begin
            w_in     = (mul_p > bcpe_pkg::MUL_PW'(bcpe_pkg::ONE_Q16)) ?
                       bcpe_pkg::ONE_Q16 : mul_p[16:0];
            state_in = S_XMUL;
         end
         S_XMUL: begin
            prod_in  = mul_p;
            state_in = S_YMUL;
         end
         S_YMUL: begin
            acc_x_in = acc_x_ff + AW'(prod_ff);
            prod_in  = mul_p;
            state_in = S_YACC;
         end
         S_YACC: begin
            acc_y_in = acc_y_ff + AW'(prod_ff);
            if (idx_ff == m_val) begin
               state_in = S_PACK;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_PINIT;
            end
         end
         S_PACK: begin
            res_x_in = sat32(acc_x_ff);
            res_y_in = sat32(acc_y_ff);
            state_in = S_DONE;
         end
         S_RSQ: begin
            rsq_in   = mul_p[33:0];
            state_in = S_PRD;
         end
         S_PRD: begin
            state_in = S_PDX;
         end
         S_PDX: begin
            dx_in = dx_abs[16:0];
            dy_in = dy_abs[16:0];
            if (dx_abs >= {16'd0, radius_ff} || dy_abs >= {16'd0, radius_ff}) begin
               if (idx_ff == m_val) begin
                  state_in = S_DONE;
               end else begin
                  idx_in   = idx_ff + IW'(1);
                  state_in = S_PRD;
               end
            end else begin
               state_in = S_SQX;
            end
         end
         S_SQX: begin
            sq_in    = mul_p[33:0];
            state_in = S_SQY;
         end
         S_SQY: begin
            prod_in  = mul_p;
            state_in = S_CMP;
         end
         S_CMP: begin
            if (dist_sum < rsq_ff) begin
               res_f_in = 4'(CMPW'(idx_ff));
               res_s_in = bcpe_pkg::ST_OK;
               state_in = S_DONE;
            end else if (idx_ff == m_val) begin
               state_in = S_DONE;
            end else begin
               idx_in   = idx_ff + IW'(1);
               state_in = S_PRD;
            end
         end
         S_DONE: begin
            if (!rsp_valid_ff || rsp_ready) begin
               rsp_load = 1'b1;
               state_in = S_IDLE;
            end
         end
         default: begin
            state_in = S_IDLE;
         end
      endcase
   end

   assign rsp_valid_in = rsp_load ? 1'b1 : (rsp_valid_ff && !rsp_ready);

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= S_IDLE;
         count_ff     <= '0;
         radius_ff    <= bcpe_pkg::PICK_RESET;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         count_ff     <= count_in;
         rsp_valid_ff <= rsp_valid_in;
         if (csr_wr_en) begin
            radius_ff <= csr_wr_data;
         end
      end
   end

   always_ff @(posedge clock) begin
      px_ff    <= px_in;
      py_ff    <= py_in;
      t_ff     <= t_in;
      idx_ff   <= idx_in;
      k_ff     <= k_in;
      p_ff     <= p_in;
      w_ff     <= w_in;
      prod_ff  <= prod_in;
      acc_x_ff <= acc_x_in;
      acc_y_ff <= acc_y_in;
      dx_ff    <= dx_in;
      dy_ff    <= dy_in;
      sq_ff    <= sq_in;
      rsq_ff   <= rsq_in;
      res_x_ff <= res_x_in;
      res_y_ff <= res_y_in;
      res_f_ff <= res_f_in;
      res_s_ff <= res_s_in;
      if (rsp_load) begin
         rsp_x_ff <= res_x_ff;
         rsp_y_ff <= res_y_ff;
         rsp_f_ff <= res_f_ff;
         rsp_s_ff <= res_s_ff;
      end
   end

   // Pascal row lanes: each lane but the first adds its left neighbor, saturating at the cap.
   always_ff @(posedge clock) begin
      if (row_init) begin
         for (int j = 0; j < MAX_POINTS; j++) begin
            row_ff[j] <= (j == 0) ? 17'd1 : 17'd0;
         end
      end else if (row_step) begin
         for (int j = 1; j < MAX_POINTS; j++) begin
            row_ff[j] <= (({1'b0, row_ff[j]} + {1'b0, row_ff[j-1]}) >
                          {1'b0, bcpe_pkg::BINOM_CAP}) ? bcpe_pkg::BINOM_CAP :
                         17'(({1'b0, row_ff[j]} + {1'b0, row_ff[j-1]}));
         end
      end
   end

   assign rsp_valid       = rsp_valid_ff;
   assign rsp_out_x       = rsp_x_ff;
   assign rsp_out_y       = rsp_y_ff;
   assign rsp_found_index = rsp_f_ff;
   assign rsp_status      = rsp_s_ff;

endmodule
`default_nettype wire

### rtl/bcpe_mul.sv
`timescale 1ns / 1ps
`default_nettype none
// Shared signed multiplier; the sequencer registers its product.
module bcpe_mul (
   input  wire logic signed [bcpe_pkg::MUL_AW-1:0] mul_a,
   input  wire logic signed [bcpe_pkg::MUL_BW-1:0] mul_b,
   output logic signed [bcpe_pkg::MUL_PW-1:0]      mul_p
);

   logic signed [bcpe_pkg::MUL_PW-1:0] a_ext;
   logic signed [bcpe_pkg::MUL_PW-1:0] b_ext;

   assign a_ext = bcpe_pkg::MUL_PW'(mul_a);
   assign b_ext = bcpe_pkg::MUL_PW'(mul_b);
   assign mul_p = a_ext * b_ext;

endmodule
`default_nettype wire

### rtl/bcpe_checker.sv
`timescale 1ns / 1ps
`default_nettype none
`include "bezier_curve_point_eval_top_macros.svh"
module bcpe_checker (
   input wire logic        clock,
   input wire logic        reset,
   input wire logic        req_valid,
   input wire logic        req_ready,
   input wire logic        rsp_valid,
   input wire logic        rsp_ready,
   input wire logic [31:0] rsp_out_x,
   input wire logic [31:0] rsp_out_y,
   input wire logic [3:0]  rsp_found_index,
   input wire logic [1:0]  rsp_status
);

   // A stalled result item keeps its status.
   `BCPE_ASSERT_NEXT(a_rsp_hold, clock, reset, rsp_valid && !rsp_ready, rsp_valid && $stable(rsp_status))

   // One item at a time: after an item is taken, the block is busy.
   `BCPE_ASSERT_NEXT(a_busy_after_accept, clock, reset, req_valid && req_ready, !req_ready)

   // A curve point only comes with an ok status.
   `BCPE_ASSERT_NOW(a_xy_ok, clock, reset, rsp_valid && (rsp_out_x != 32'd0 || rsp_out_y != 32'd0), rsp_status == bcpe_pkg::ST_OK)

   // A nonzero found index only comes with an ok status.
   `BCPE_ASSERT_NOW(a_found_ok, clock, reset, rsp_valid && rsp_found_index != 4'd0, rsp_status == bcpe_pkg::ST_OK)

endmodule

bind bezier_curve_point_eval_top bcpe_checker u_bcpe_checker (
   .clock           (clock),
   .reset           (reset),
   .req_valid       (req_valid),
   .req_ready       (req_ready),
   .rsp_valid       (rsp_valid),
   .rsp_ready       (rsp_ready),
   .rsp_out_x       (rsp_out_x),
   .rsp_out_y       (rsp_out_y),
   .rsp_found_index (rsp_found_index),
   .rsp_status      (rsp_status)
);
`default_nettype wire

### verif/bcpe_checker.sv
`timescale 1ns / 1ps
// Scoreboard for the Bezier point evaluator: mirrors the point table and the
// pick radius, predicts one response per accepted request and compares it.
module bcpe_scoreboard (
   input  wire logic        clock,
   input  wire logic        reset,
   input  wire logic        req_valid,
   input  wire logic        req_ready,
   input  wire logic [1:0]  req_type,
   input  wire logic [31:0] req_px,
   input  wire logic [31:0] req_py,
   input  wire logic [16:0] req_t_param,
   input  wire logic [3:0]  req_point_index,
   input  wire logic        rsp_valid,
   input  wire logic        rsp_ready,
   input  wire logic [31:0] rsp_out_x,
   input  wire logic [31:0] rsp_out_y,
   input  wire logic [3:0]  rsp_found_index,
   input  wire logic [1:0]  rsp_status,
   input  wire logic        csr_wr_en,
   input  wire logic [16:0] csr_wr_data,
   output int               mismatches,
   output int               outstanding,
   output int               evals_checked,
   output int               picks_hit
);

   typedef struct packed {
      logic [31:0] x;
      logic [31:0] y;
      logic [3:0]  idx;
      logic [1:0]  st;
   } curve_rsp_type;

   localparam int TABLE_DEPTH = bcpe_pkg::MAX_POINTS_DEF;

   longint        tab_x [TABLE_DEPTH];
   longint        tab_y [TABLE_DEPTH];
   int            stored;
   longint        radius;
   curve_rsp_type pending_rsp [$];

   function automatic logic [31:0] to_q16_sat(longint s);
      longint q;
      q = s >>> 16;
      if (q > 64'sd2147483647) q = 64'sd2147483647;
      if (q < -64'sd2147483648) q = -64'sd2147483648;
      return q[31:0];
   endfunction

   // Bernstein-weighted sum over the stored points, weights truncated per multiply.
   function automatic void curve_point(input logic [16:0] tp,
                                       output logic [31:0] ox, output logic [31:0] oy);
      longint t, u, p, c, w, sx, sy;
      int     m;
      t = (tp > bcpe_pkg::ONE_Q16) ? 65536 : longint'(tp);
      u = 65536 - t;
      sx = 0;
      sy = 0;
      c = 1;
      ox = '0;
      oy = '0;
      if (stored == 0) return;
      m = stored - 1;
      for (int i = 0; i < stored; i++) begin
         p = 65536;
         for (int k = 0; k < i; k++) p = (p * t) >> 16;
         for (int k = 0; k < m - i; k++) p = (p * u) >> 16;
         w = c * p;
         if (w > 65536) w = 65536;
         sx += tab_x[i] * w;
         sy += tab_y[i] * w;
         if (i < m) c = c * (m - i) / (i + 1);
      end
      ox = to_q16_sat(sx);
      oy = to_q16_sat(sy);
   endfunction

   function automatic curve_rsp_type serve_request(logic [1:0] kind, logic [31:0] rx,
                                                   logic [31:0] ry, logic [16:0] tp,
                                                   logic [3:0] pidx);
      curve_rsp_type r;
      longint        x, y, dx, dy;
      x = longint'($signed(rx));
      y = longint'($signed(ry));
      r = '0;
      r.st = bcpe_pkg::ST_OK;
      case (kind)
         bcpe_pkg::REQ_APPEND: begin
            if (stored >= TABLE_DEPTH) begin
               r.st = bcpe_pkg::ST_FULL;
            end else begin
               tab_x[stored] = x;
               tab_y[stored] = y;
               stored++;
            end
         end
         bcpe_pkg::REQ_MOVE: begin
            if (int'(pidx) >= stored) begin
               r.st = bcpe_pkg::ST_BAD_IDX;
            end else begin
               tab_x[pidx] = x;
               tab_y[pidx] = y;
            end
         end
         bcpe_pkg::REQ_EVAL: begin
            curve_point(tp, r.x, r.y);
         end
         default: begin
            r.st = bcpe_pkg::ST_NONE;
            for (int i = 0; i < stored; i++) begin
               dx = x - tab_x[i];
               dy = y - tab_y[i];
               if (dx < 0) dx = -dx;
               if (dy < 0) dy = -dy;
               if (dx >= radius || dy >= radius) continue;
               if (dx * dx + dy * dy < radius * radius) begin
                  r.idx = i[3:0];
                  r.st = bcpe_pkg::ST_OK;
                  break;
               end
            end
         end
      endcase
      return r;
   endfunction

   always @(posedge clock) begin
      curve_rsp_type want, got;
      if (reset) begin
         stored = 0;
         radius = longint'(bcpe_pkg::PICK_RESET);
         pending_rsp.delete();
         mismatches = 0;
         evals_checked = 0;
         picks_hit = 0;
      end else begin
         if (csr_wr_en) radius = longint'(csr_wr_data);
         if (rsp_valid && rsp_ready) begin
            got = '{rsp_out_x, rsp_out_y, rsp_found_index, rsp_status};
            if (pending_rsp.size() == 0) begin
               mismatches++;
               if (mismatches <= 10)
                  $display("%0t: unexpected response %h", $realtime, got);
            end else begin
               want = pending_rsp.pop_front();
               if (got !== want) begin
                  mismatches++;
                  if (mismatches <= 10)
                     $display("%0t: mismatch x %h/%h y %h/%h idx %0d/%0d st %0d/%0d",
                              $realtime, want.x, got.x, want.y, got.y,
                              want.idx, got.idx, want.st, got.st);
               end
            end
         end
         if (req_valid && req_ready) begin
            want = serve_request(req_type, req_px, req_py, req_t_param, req_point_index);
            if (req_type == bcpe_pkg::REQ_EVAL) evals_checked++;
            if (req_type == bcpe_pkg::REQ_PICK && want.st == bcpe_pkg::ST_OK) picks_hit++;
            pending_rsp = {pending_rsp, want};
         end
      end
      outstanding = pending_rsp.size();
   end

endmodule

### verif/tb.sv
`timescale 1ns / 1ps
// Top of the testbench. It only makes stimulus: requests, response stalls and
// pick radius writes. All prediction and comparison lives in bcpe_scoreboard.
module tb;

   localparam int  TABLE_DEPTH = bcpe_pkg::MAX_POINTS_DEF;
   localparam int  RANDOM_ITEMS = 1400;
   // The slowest item is an evaluate over a full table, and requests and responses
   // also see random gaps and stalls; the limit leaves room for all of the items.
   localparam longint CYCLE_LIMIT = 3000000;

   logic        clock = 1'b0;
   logic        reset = 1'b1;
   logic        req_valid = 1'b0;
   logic        req_ready;
   logic [1:0]  req_type = bcpe_pkg::REQ_EVAL;
   logic [31:0] req_px = '0;
   logic [31:0] req_py = '0;
   logic [16:0] req_t_param = '0;
   logic [3:0]  req_point_index = '0;
   logic        rsp_valid;
   logic        rsp_ready = 1'b0;
   logic [31:0] rsp_out_x;
   logic [31:0] rsp_out_y;
   logic [3:0]  rsp_found_index;
   logic [1:0]  rsp_status;
   logic        csr_wr_en = 1'b0;
   logic [16:0] csr_wr_data = '0;

   int          mismatches;
   int          outstanding;
   int          evals_checked;
   int          picks_hit;
   longint      cycles = 0;

   // When set, both sides run back to back so that long unbroken bursts occur.
   bit          no_idle = 1'b0;

   // A copy of what has been stored, used to aim picks near real points and to track the fill.
   logic [31:0] aim_x [TABLE_DEPTH];
   logic [31:0] aim_y [TABLE_DEPTH];
   int          aim_count = 0;
   logic [16:0] cur_radius = bcpe_pkg::PICK_RESET;

   always #4 clock = ~clock;

   bezier_curve_point_eval_top uut (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_px(req_px), .req_py(req_py), .req_t_param(req_t_param),
      .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_found_index(rsp_found_index), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data)
   );

   bcpe_scoreboard chk (
      .clock(clock), .reset(reset),
      .req_valid(req_valid), .req_ready(req_ready), .req_type(req_type),
      .req_px(req_px), .req_py(req_py), .req_t_param(req_t_param),
      .req_point_index(req_point_index),
      .rsp_valid(rsp_valid), .rsp_ready(rsp_ready), .rsp_out_x(rsp_out_x),
      .rsp_out_y(rsp_out_y), .rsp_found_index(rsp_found_index), .rsp_status(rsp_status),
      .csr_wr_en(csr_wr_en), .csr_wr_data(csr_wr_data),
      .mismatches(mismatches), .outstanding(outstanding),
      .evals_checked(evals_checked), .picks_hit(picks_hit)
   );

   // Watchdog. A hung handshake ends the run here.
   always @(posedge clock) begin
      cycles <= cycles + 1;
      if (cycles > CYCLE_LIMIT) begin
         $display("timeout after %0d cycles, %0d responses outstanding", cycles, outstanding);
         $display("*** FAILED ***");
         $finish;
      end
   end

   // Response side. For every item the receiver draws a stall before raising
   // ready. Ready is only lowered when a real stall follows, so it is never
   // dropped and raised within the same time step.
   initial begin : response_sink
      int stall;
      @(negedge clock);
      while (reset) @(negedge clock);
      forever begin
         stall = no_idle ? 0 : $urandom_range(0, 17);
         if (stall > 0) begin
            rsp_ready <= 1'b0;
            repeat (stall) @(negedge clock);
         end
         rsp_ready <= 1'b1;
         do @(posedge clock); while (!(rsp_valid && rsp_ready));
         @(negedge clock);
      end
   end

   // Presents one request and holds it until accepted. Every call starts and
   // ends just after a falling edge, so valid changes only there.
   task automatic send_request(logic [1:0] kind, logic [31:0] x, logic [31:0] y,
                               logic [16:0] tp, logic [3:0] pidx);
      int gap;
      gap = no_idle ? 0 : $urandom_range(0, 17);
      if (gap > 0) begin
         req_valid <= 1'b0;
         repeat (gap) @(negedge clock);
      end
      req_type        <= kind;
      req_px          <= x;
      req_py          <= y;
      req_t_param     <= tp;
      req_point_index <= pidx;
      req_valid       <= 1'b1;
      do @(posedge clock); while (!(req_valid && req_ready));
      @(negedge clock);
      // Keep the aiming copy in step with the table.
      if (kind == bcpe_pkg::REQ_APPEND && aim_count < TABLE_DEPTH) begin
         aim_x[aim_count] = x;
         aim_y[aim_count] = y;
         aim_count++;
      end else if (kind == bcpe_pkg::REQ_MOVE && int'(pidx) < aim_count) begin
         aim_x[pidx] = x;
         aim_y[pidx] = y;
      end
   endtask

   // Stops the sender until every predicted response has come back.
   task automatic drain_responses();
      req_valid <= 1'b0;
      while (outstanding != 0) @(negedge clock);
      @(negedge clock);
   endtask

   // The register may only change while the block is idle, so drain first.
   task automatic write_pick_radius(logic [16:0] value);
      drain_responses();
      csr_wr_en   <= 1'b1;
      csr_wr_data <= value;
      @(negedge clock);
      csr_wr_en   <= 1'b0;
      cur_radius   = value;
      @(negedge clock);
   endtask

   // Coordinates: full-range random, small or extreme, each about a third of the time.
   function automatic logic [31:0] pick_coord();
      case ($urandom_range(0, 5))
         0:       return 32'h7FFF_FFFF;
         1:       return 32'h8000_0000;
         2, 3:    return $urandom_range(0, 32'h0004_0000) - 32'h0002_0000;
         default: return $urandom;
      endcase
   endfunction

   // A point within roughly the pick radius of a stored entry, or anywhere.
   task automatic send_pick();
      int          sel;
      logic [31:0] ox, oy;
      if (aim_count > 0 && $urandom_range(0, 3) != 0) begin
         sel = $urandom_range(0, aim_count - 1);
         ox  = $urandom_range(0, 2 * cur_radius) - cur_radius;
         oy  = $urandom_range(0, 2 * cur_radius) - cur_radius;
         send_request(bcpe_pkg::REQ_PICK, aim_x[sel] + ox, aim_y[sel] + oy,
                      17'($urandom), 4'($urandom));
      end else begin
         send_request(bcpe_pkg::REQ_PICK, pick_coord(), pick_coord(),
                      17'($urandom), 4'($urandom));
      end
   endtask

   function automatic logic [16:0] pick_t();
      case ($urandom_range(0, 7))
         0:       return 17'd0;
         1:       return bcpe_pkg::ONE_Q16;
         2:       return 17'($urandom_range(65537, 131071));
         default: return 17'($urandom_range(0, 65536));
      endcase
   endfunction

   initial begin : stimulus
      logic [16:0] radius_set [5];
      int          kind_roll;
      radius_set = '{17'd0, bcpe_pkg::ONE_Q16, 17'd1, bcpe_pkg::PICK_RESET, 17'd30000};

      repeat (12) @(posedge clock);
      @(negedge clock);
      reset <= 1'b0;
      @(negedge clock);

      // Directed part. An empty table evaluates to the origin, including a
      // parameter above one, and a move into an empty table is a bad index.
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, 17'd0, '0);
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, 17'h1FFFF, '0);
      send_request(bcpe_pkg::REQ_MOVE, 32'h1234_5678, 32'h9ABC_DEF0, '0, 4'd0);
      send_request(bcpe_pkg::REQ_PICK, '0, '0, '0, '0);
      // Extreme coordinates, so the saturated sums and both sign bits show up.
      send_request(bcpe_pkg::REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, 17'd32768, '0);
      send_request(bcpe_pkg::REQ_APPEND, 32'h7FFF_FFFF, 32'h7FFF_FFFF, '0, '0);
      send_request(bcpe_pkg::REQ_APPEND, 32'h8000_0000, 32'h0001_0000, '0, '0);
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, bcpe_pkg::ONE_Q16, '0);
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, 17'd21845, '0);
      send_request(bcpe_pkg::REQ_MOVE, 32'h0000_1000, 32'hFFFF_F000, '0, 4'd1);
      send_request(bcpe_pkg::REQ_MOVE, '0, '0, '0, 4'd15);
      // Picks that just hit and just miss the default radius.
      send_request(bcpe_pkg::REQ_PICK, 32'h0000_1000 + 32'd6553, 32'hFFFF_F000, '0, '0);
      send_request(bcpe_pkg::REQ_PICK, 32'h0000_1000 + 32'd6554, 32'hFFFF_F000, '0, '0);
      // A zero radius never picks anything; the widest radius picks readily.
      write_pick_radius(17'd0);
      send_request(bcpe_pkg::REQ_PICK, 32'h0000_1000, 32'hFFFF_F000, '0, '0);
      write_pick_radius(bcpe_pkg::ONE_Q16);
      send_request(bcpe_pkg::REQ_PICK, 32'h0000_1000 + 32'd65535, 32'hFFFF_F000, '0, '0);
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, 17'd1, '0);

      // Random part. Appends are rare so the table grows slowly and every
      // size from a few points up to full gets its share of evaluates.
      for (int n = 0; n < RANDOM_ITEMS; n++) begin
         if (n % 200 == 100) no_idle = ~no_idle;
         if (n % 250 == 0) write_pick_radius(radius_set[(n / 250) % 5]);
         if (n % 300 == 150) write_pick_radius(17'($urandom_range(0, 65536)));
         // The sender holds off entirely now and then until all is back.
         if (n % 333 == 7) drain_responses();
         kind_roll = $urandom_range(0, 99);
         if (kind_roll < 4 || (aim_count == TABLE_DEPTH && kind_roll < 6))
            send_request(bcpe_pkg::REQ_APPEND, pick_coord(), pick_coord(),
                         17'($urandom), 4'($urandom));
         else if (kind_roll < 30)
            send_request(bcpe_pkg::REQ_MOVE, pick_coord(), pick_coord(), 17'($urandom),
                         4'($urandom_range(0, 15)));
         else if (kind_roll < 65)
            send_request(bcpe_pkg::REQ_EVAL, $urandom, $urandom, pick_t(), 4'($urandom));
         else
            send_pick();
      end

      // Make sure the table filled, then knock on a full table once more.
      while (aim_count < TABLE_DEPTH)
         send_request(bcpe_pkg::REQ_APPEND, pick_coord(), pick_coord(), '0, '0);
      send_request(bcpe_pkg::REQ_APPEND, 32'h7FFF_FFFF, 32'h8000_0000, '0, '0);
      send_request(bcpe_pkg::REQ_EVAL, '0, '0, 17'd32768, '0);

      drain_responses();
      repeat (20) @(negedge clock);

      $display("Covered %0d evaluates and %0d successful picks over table sizes 0 to %0d,",
               evals_checked, picks_hit, TABLE_DEPTH);
      $display("with random gaps and stalls and several pick radius settings.");
      if (mismatches == 0) begin
         $display("*** PASSED ***");
      end else begin
         $display("%0d mismatches", mismatches);
         $display("*** FAILED ***");
      end
      $finish;
   end

endmodule

### files.f
+incdir+rtl
rtl/bcpe_pkg.sv
rtl/bcpe_mul.sv
rtl/bezier_curve_point_eval_top.sv
rtl/bcpe_checker.sv
verif/bcpe_checker.sv
verif/tb.sv
